[src/joystick_axis_conditioning_defines.svh]
// ----------------------------------------------------------------------------
// Joystick axis conditioning - assertion macros
// Shared property shorthands for the block's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef JOYSTICK_AXIS_CONDITIONING_DEFINES_SVH
`define JOYSTICK_AXIS_CONDITIONING_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off while in reset
`define JAC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off while in reset
`define JAC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/jac_pkg.sv]
// ----------------------------------------------------------------------------
// Joystick axis conditioning - package
// Widths, fixed constants and the divider request/response types.
// ----------------------------------------------------------------------------
package jac_pkg;

    localparam int RAW_W      = 12;
    localparam int AXIS_W     = 8;
    localparam int DZ_W       = 12;
    localparam int SENS_W     = 16;
    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int MAG_W      = 7;

    localparam int DIVIDEND_W = 18;
    localparam int DIVISOR_W  = 12;
    localparam int QUOT_W     = 12;
    localparam int STEP_W     = 4;
    localparam int DEN_W      = DIVISOR_W + QUOT_W - 1;
    localparam int PROD_W     = QUOT_W + SENS_W;

    localparam logic [RAW_W:0]      CENTRE      = 13'd2048;
    localparam logic [DZ_W-1:0]     DZ_KNEE     = 12'd1948;
    localparam logic [DIVISOR_W-1:0] RANGE_MIN  = 12'd100;
    localparam logic [DIVISOR_W-1:0] GAIN_DIV   = 12'd1000;
    localparam logic [SENS_W-1:0]   GAIN_UNITY  = 16'd1000;
    localparam logic [MAG_W-1:0]    AXIS_MAX    = 7'd127;
    localparam logic [PROD_W-1:0]   SAT_LIMIT   = 28'd128000;
    localparam logic [STEP_W-1:0]   DIV1_STEPS  = 4'd12;
    localparam logic [STEP_W-1:0]   DIV2_STEPS  = 4'd7;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEADZONE = 2'd0,
        CFG_SENS     = 2'd1,
        CFG_INV_X    = 2'd2,
        CFG_INV_Y    = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [DIVISOR_W-1:0]  divisor;
        logic [STEP_W-1:0]     steps;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [QUOT_W-1:0] quot;
    } t_div_rsp;

endpackage

[src/joystick_axis_conditioning.sv]
// ----------------------------------------------------------------------------
// Joystick axis conditioning - top level
// Centres, dead-zones, scales, saturates and inverts two ADC axes and
// debounces the stick button.
// ----------------------------------------------------------------------------
// Input channel: i_in_valid / o_in_stall with i_raw_x, i_raw_y, i_button_raw.
// A beat is taken when i_in_valid is high and o_in_stall is low.
// Output channel: o_out_valid / i_out_stall with o_axis_x, o_axis_y,
// o_button_stable; one output beat per input beat, in order.
// Config: i_cfg_we writes i_cfg_data to register i_cfg_idx (0 deadzone,
// 1 sensitivity, 2 invert X, 3 invert Y); write only while idle.
// Each axis runs through one shared shift-subtract divider: a 12-step
// divide by the scaling range, a registered multiply by the gain, then a
// 7-step divide by 1000 that is skipped when the product saturates.
// o_in_stall is high while the two axes are worked and until the result
// has been loaded into the output register.
// A result held by i_out_stall does not block the next input beat; only
// completion of that next one waits for the output register to free up.
// Reset restores the register defaults and releases the button.
// ----------------------------------------------------------------------------
`include "joystick_axis_conditioning_defines.svh"

module joystick_axis_conditioning
    import jac_pkg::*;
#(
    parameter int DEBOUNCE_COUNT = 3
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic [RAW_W-1:0]        i_raw_x,
    input  logic [RAW_W-1:0]        i_raw_y,
    input  logic                    i_button_raw,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic signed [AXIS_W-1:0] o_axis_x,
    output logic signed [AXIS_W-1:0] o_axis_y,
    output logic                    o_button_stable,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [CFG_W-1:0]        i_cfg_data
);

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_PREP = 8'b0000_0010,
        S_DIV1 = 8'b0000_0100,
        S_MUL  = 8'b0000_1000,
        S_CHK  = 8'b0001_0000,
        S_DIV2 = 8'b0010_0000,
        S_FIN  = 8'b0100_0000,
        S_DONE = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    logic [DZ_W-1:0]   r_deadzone;
    logic [SENS_W-1:0] r_sens;
    logic              r_inv_x, r_inv_y;

    logic [RAW_W-1:0]  r_raw_x, r_raw_y;
    logic              r_axis, n_axis;
    logic [QUOT_W-1:0] r_q1, n_q1;
    logic [PROD_W-1:0] r_prod, n_prod;
    logic [MAG_W-1:0]  r_mag, n_mag;
    logic signed [AXIS_W-1:0] r_res_x, n_res_x;
    logic signed [AXIS_W-1:0] r_res_y, n_res_y;

    logic              r_out_valid, n_out_valid;
    logic signed [AXIS_W-1:0] r_out_x, r_out_y;
    logic              r_out_btn;
    logic              out_load;

    logic              in_take;
    logic              btn_stable;
    t_div_req          div_req;
    t_div_rsp          div_rsp;

    logic [RAW_W-1:0]  cur_raw;
    logic              cur_inv;
    logic              is_neg;
    logic [RAW_W-1:0]  mag;
    logic [RAW_W:0]    range_full;
    logic [DIVISOR_W-1:0] range;
    logic [DIVIDEND_W:0] scaled;
    logic [DIVIDEND_W-1:0] dividend1;
    logic [SENS_W-1:0] gain;
    logic [AXIS_W-1:0] mag_ext;
    logic signed [AXIS_W-1:0] axis_res;

    logic              div_waiting;
    logic              out_in_range;

    assign in_take    = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);

    jac_debounce #(
        .DEBOUNCE_COUNT(DEBOUNCE_COUNT)
    ) u_debounce (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_sample       (in_take),
        .i_button_raw   (i_button_raw),
        .o_button_stable(btn_stable)
    );

    jac_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (div_req),
        .o_rsp  (div_rsp)
    );

    // per-axis front end: centre, magnitude, zero zone, range
    always_comb begin
        cur_raw    = r_axis ? r_raw_y : r_raw_x;
        cur_inv    = r_axis ? r_inv_y : r_inv_x;
        is_neg     = !cur_raw[RAW_W-1];
        mag        = is_neg ? RAW_W'(CENTRE - {1'b0, cur_raw})
                            : {1'b0, cur_raw[RAW_W-2:0]};
        range_full = CENTRE - {1'b0, r_deadzone};
        range      = (r_deadzone > DZ_KNEE) ? RANGE_MIN : range_full[DIVISOR_W-1:0];
        // mag * 127 as shift and subtract
        scaled     = {mag, 7'b0} - {{(DIVIDEND_W+1-RAW_W){1'b0}}, mag};
        dividend1  = (mag < r_deadzone) ? '0 : scaled[DIVIDEND_W-1:0];
        gain       = (r_sens == '0) ? GAIN_UNITY : r_sens;
        mag_ext    = {1'b0, r_mag};
        axis_res   = (is_neg ^ cur_inv) ? -$signed(mag_ext) : $signed(mag_ext);
    end

    assign out_load = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);

    always_comb begin
        n_state     = r_state;
        n_axis      = r_axis;
        n_q1        = r_q1;
        n_prod      = r_prod;
        n_mag       = r_mag;
        n_res_x     = r_res_x;
        n_res_y     = r_res_y;
        div_req     = '0;
        n_out_valid = r_out_valid;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (in_take) begin
                    n_axis  = 1'b0;
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                div_req.start    = 1'b1;
                div_req.dividend = dividend1;
                div_req.divisor  = range;
                div_req.steps    = DIV1_STEPS;
                n_state          = S_DIV1;
            end
            S_DIV1: begin
                if (div_rsp.done) begin
                    n_q1    = div_rsp.quot;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_prod  = PROD_W'(r_q1) * PROD_W'(gain);
                n_state = S_CHK;
            end
            S_CHK: begin
                if (r_prod >= SAT_LIMIT) begin
                    n_mag   = AXIS_MAX;
                    n_state = S_FIN;
                end else begin
                    div_req.start    = 1'b1;
                    div_req.dividend = r_prod[DIVIDEND_W-1:0];
                    div_req.divisor  = GAIN_DIV;
                    div_req.steps    = DIV2_STEPS;
                    n_state          = S_DIV2;
                end
            end
            S_DIV2: begin
                if (div_rsp.done) begin
                    n_mag   = div_rsp.quot[MAG_W-1:0];
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (!r_axis) begin
                    n_res_x = axis_res;
                    n_axis  = 1'b1;
                    n_state = S_PREP;
                end else begin
                    n_res_y = axis_res;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // hold until the output register is free
                if (out_load) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_axis      <= 1'b0;
            r_out_valid <= 1'b0;
            r_deadzone  <= '0;
            r_sens      <= GAIN_UNITY;
            r_inv_x     <= 1'b0;
            r_inv_y     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_axis      <= n_axis;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_DEADZONE: r_deadzone <= i_cfg_data[DZ_W-1:0];
                    CFG_SENS:     r_sens     <= i_cfg_data[SENS_W-1:0];
                    CFG_INV_X:    r_inv_x    <= i_cfg_data[0];
                    CFG_INV_Y:    r_inv_y    <= i_cfg_data[0];
                    default:      r_inv_y    <= r_inv_y;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_raw_x <= i_raw_x;
            r_raw_y <= i_raw_y;
        end
        r_q1    <= n_q1;
        r_prod  <= n_prod;
        r_mag   <= n_mag;
        r_res_x <= n_res_x;
        r_res_y <= n_res_y;
        if (out_load) begin
            r_out_x   <= r_res_x;
            r_out_y   <= r_res_y;
            r_out_btn <= btn_stable;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_axis_x        = r_out_x;
    assign o_axis_y        = r_out_y;
    assign o_button_stable = r_out_btn;

    assign div_waiting  = (r_state == S_DIV1) || (r_state == S_DIV2);
    assign out_in_range = (o_axis_x != -8'sd128) && (o_axis_y != -8'sd128);

    `JAC_ASSERT_NXT(a_take_starts, in_take, r_state == S_PREP, "accepted beat did not start work")
    `JAC_ASSERT_IMP(a_div_owner, div_rsp.done, div_waiting, "divider done with no step waiting")
    `JAC_ASSERT_IMP(a_axis_range, o_out_valid, out_in_range, "axis result outside +/-127")

endmodule

[src/jac_div.sv]
// ----------------------------------------------------------------------------
// Joystick axis conditioning - shared divider
// Shift-and-subtract unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module jac_div
    import jac_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic                  r_busy, n_busy;
    logic                  r_done, n_done;
    logic [STEP_W-1:0]     r_cnt, n_cnt;
    logic [DIVIDEND_W-1:0] r_rem, n_rem;
    logic [DEN_W-1:0]      r_den, n_den;
    logic [QUOT_W-1:0]     r_quot, n_quot;
    logic                  fits;

    assign fits = {{(DEN_W-DIVIDEND_W){1'b0}}, r_rem} >= r_den;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_den  = r_den;
        n_quot = r_quot;
        if (i_req.start) begin
            // align divisor with the top quotient bit
            n_den  = DEN_W'(i_req.divisor) << (i_req.steps - 1'b1);
            n_rem  = i_req.dividend;
            n_quot = '0;
            n_cnt  = i_req.steps;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (fits) begin
                n_rem = r_rem - r_den[DIVIDEND_W-1:0];
            end
            n_quot = {r_quot[QUOT_W-2:0], fits};
            n_den  = r_den >> 1;
            n_cnt  = r_cnt - 1'b1;
            if (r_cnt == STEP_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_den  <= n_den;
        r_quot <= n_quot;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;

endmodule

[src/jac_debounce.sv]
// ----------------------------------------------------------------------------
// Joystick axis conditioning - button debounce
// Stable state flips after a run of consecutive disagreeing samples.
// ----------------------------------------------------------------------------
module jac_debounce
    import jac_pkg::*;
#(
    parameter int DEBOUNCE_COUNT = 3
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_sample,
    input  logic i_button_raw,
    output logic o_button_stable
);

    localparam int CNT_W = $clog2(DEBOUNCE_COUNT + 1);
    localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(DEBOUNCE_COUNT);

    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_state, n_state;
    logic [CNT_W-1:0] cnt_inc;

    always_comb begin
        n_cnt   = r_cnt;
        n_state = r_state;
        cnt_inc = (r_cnt < CNT_LIMIT) ? r_cnt + 1'b1 : r_cnt;
        if (i_sample) begin
            if (i_button_raw == r_state) begin
                n_cnt = '0;
            end else if (cnt_inc >= CNT_LIMIT) begin
                n_state = i_button_raw;
                n_cnt   = '0;
            end else begin
                n_cnt = cnt_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_state <= 1'b0;
        end else begin
            r_cnt   <= n_cnt;
            r_state <= n_state;
        end
    end

    assign o_button_stable = r_state;

endmodule

[tb/tb_joystick_axis_conditioning.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Joystick axis conditioning - testbench
// Feeds ADC sample pairs and button bits through the valid/stall channels,
// predicts every conditioned beat and checks each one as it leaves the block.
// Settings change between phases once the block has drained.
// ----------------------------------------------------------------------------
module tb_joystick_axis_conditioning
    import jac_pkg::*;
();

    localparam int DEBOUNCE   = 3;
    localparam int TIMEOUT    = 600000;
    localparam int CALM_FIRST = 30000;
    localparam int CALM_LAST  = 50000;

    typedef struct packed {
        logic [RAW_W-1:0] x;
        logic [RAW_W-1:0] y;
        logic             btn;
    } t_stick_sample;

    typedef struct packed {
        logic signed [AXIS_W-1:0] ax;
        logic signed [AXIS_W-1:0] ay;
        logic                     btn;
    } t_stick_report;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     o_in_stall;
    logic [RAW_W-1:0]         raw_x = '0;
    logic [RAW_W-1:0]         raw_y = '0;
    logic                     button_raw = 1'b0;
    logic                     o_out_valid;
    logic                     out_stall = 1'b0;
    logic signed [AXIS_W-1:0] o_axis_x;
    logic signed [AXIS_W-1:0] o_axis_y;
    logic                     o_button_stable;
    logic                     cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]     cfg_idx = '0;
    logic [CFG_W-1:0]         cfg_data = '0;

    t_stick_sample pending_samples[$];
    t_stick_report expected_reports[$];

    // predictor copies of the registers and debounce state
    logic [DZ_W-1:0]   dz_q   = '0;
    logic [SENS_W-1:0] sens_q = GAIN_UNITY;
    logic              inv_x_q = 1'b0;
    logic              inv_y_q = 1'b0;
    int unsigned       btn_run = 0;
    logic              btn_held = 1'b0;

    int errors = 0;
    int cycle_count = 0;

    joystick_axis_conditioning #(
        .DEBOUNCE_COUNT(DEBOUNCE)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (in_valid),
        .o_in_stall      (o_in_stall),
        .i_raw_x         (raw_x),
        .i_raw_y         (raw_y),
        .i_button_raw    (button_raw),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (out_stall),
        .o_axis_x        (o_axis_x),
        .o_axis_y        (o_axis_y),
        .o_button_stable (o_button_stable),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic signed [AXIS_W-1:0] scale_axis(logic [RAW_W-1:0] raw, logic inv);
        longint v;
        longint dz;
        longint span;
        longint gain;
        v    = longint'(raw) - 2048;
        dz   = longint'(dz_q);
        span = 2048 - dz;
        gain = (sens_q == '0) ? 1000 : longint'(sens_q);
        if (span < 100) span = 100;
        if (v > -dz && v < dz) v = 0;
        v = (v * 127) / span;
        v = (v * gain) / 1000;
        if (v > 127) v = 127;
        if (v < -127) v = -127;
        if (inv) v = -v;
        return v[AXIS_W-1:0];
    endfunction

    function automatic t_stick_report predict_report(t_stick_sample s);
        t_stick_report r;
        r.ax = scale_axis(s.x, inv_x_q);
        r.ay = scale_axis(s.y, inv_y_q);
        // count disagreeing samples; an agreeing one clears the run
        if (s.btn == btn_held) begin
            btn_run = 0;
        end else begin
            if (btn_run < DEBOUNCE) btn_run++;
            if (btn_run >= DEBOUNCE) begin
                btn_held = s.btn;
                btn_run  = 0;
            end
        end
        r.btn = btn_held;
        return r;
    endfunction

    function automatic bit calm();
        return cycle_count >= CALM_FIRST && cycle_count < CALM_LAST;
    endfunction

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= TIMEOUT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // input driver
    always @(posedge i_clk) begin
        t_stick_sample s;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || !o_in_stall) begin
            if (in_valid)
                expected_reports.push_back(predict_report('{raw_x, raw_y, button_raw}));
            if (pending_samples.size() != 0 && (calm() || $urandom_range(0, 99) >= 10)) begin
                s = pending_samples.pop_front();
                raw_x      <= s.x;
                raw_y      <= s.y;
                button_raw <= s.btn;
                in_valid   <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        out_stall <= !calm() && $urandom_range(0, 99) < 10;
    end

    // output monitor
    always @(posedge i_clk) begin
        t_stick_report e;
        if (i_rst_n && o_out_valid && !out_stall) begin
            if (expected_reports.size() == 0) begin
                $error("unexpected beat: axis_x %0d axis_y %0d button_stable %0b",
                       o_axis_x, o_axis_y, o_button_stable);
                errors++;
            end else begin
                e = expected_reports.pop_front();
                if (o_axis_x !== e.ax) begin
                    $error("axis_x: expected %0d, actual %0d", e.ax, o_axis_x);
                    errors++;
                end
                if (o_axis_y !== e.ay) begin
                    $error("axis_y: expected %0d, actual %0d", e.ay, o_axis_y);
                    errors++;
                end
                if (o_button_stable !== e.btn) begin
                    $error("button_stable: expected %0b, actual %0b", e.btn, o_button_stable);
                    errors++;
                end
            end
        end
    end

    task automatic cfg_write(t_cfg_idx idx, logic [CFG_W-1:0] data);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        case (idx)
            CFG_DEADZONE: dz_q    = data[DZ_W-1:0];
            CFG_SENS:     sens_q  = data[SENS_W-1:0];
            CFG_INV_X:    inv_x_q = data[0];
            CFG_INV_Y:    inv_y_q = data[0];
            default: ;
        endcase
    endtask

    task automatic set_config(logic [CFG_W-1:0] dz, logic [CFG_W-1:0] sens,
                              logic [CFG_W-1:0] ix, logic [CFG_W-1:0] iy);
        cfg_write(CFG_DEADZONE, dz);
        cfg_write(CFG_SENS, sens);
        cfg_write(CFG_INV_X, ix);
        cfg_write(CFG_INV_Y, iy);
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic add_sample(int x, int y, int b);
        pending_samples.push_back('{x[RAW_W-1:0], y[RAW_W-1:0], b[0]});
    endtask

    // hold until every accepted beat has come back
    task automatic drain();
        while (pending_samples.size() != 0 || in_valid || expected_reports.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic int pick_raw();
        int v;
        int dz;
        dz = int'(dz_q);
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 8: v = $urandom_range(0, 4095);
            4: begin
                case ($urandom_range(0, 2))
                    0: v = 0;
                    1: v = 4095;
                    default: v = 2048;
                endcase
            end
            5, 6: begin
                v = $urandom_range(0, 1) ? 2048 + dz : 2048 - dz;
                v = v + $urandom_range(0, 4) - 2;
            end
            default: v = 2048 + $urandom_range(0, 80) - 40;
        endcase
        if (v < 0) v = 0;
        if (v > 4095) v = 4095;
        return v;
    endfunction

    initial begin
        bit btn;
        logic [CFG_W-1:0] dz;
        logic [CFG_W-1:0] sens;
        btn = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset defaults: extremes, centre, and the debounce run
        add_sample(2048, 2048, 0);
        add_sample(0, 4095, 1);
        add_sample(4095, 0, 1);
        add_sample(2047, 2049, 1);
        add_sample(1, 4094, 0);
        add_sample(2048, 2048, 1);
        add_sample(2049, 2047, 0);
        add_sample(3000, 1000, 0);
        add_sample(1000, 3000, 0);
        drain();

        // deadzone edges, zero sensitivity, both axes inverted
        set_config(16'd100, 16'd0, 16'd1, 16'd1);
        add_sample(2148, 1948, 0);
        add_sample(2147, 1949, 0);
        add_sample(2149, 1947, 0);
        add_sample(0, 4095, 0);
        drain();

        // range floor with maximum gain: saturates before inversion
        set_config(16'd2000, 16'hFFFF, 16'd1, 16'd0);
        add_sample(2047, 2049, 1);
        add_sample(4095, 0, 1);
        add_sample(48, 4048, 1);
        drain();

        // deadzone beyond the full scale: everything inside the zone
        set_config(16'hFFFF, 16'd1, 16'd0, 16'd0);
        add_sample(0, 4095, 0);
        add_sample(4095, 0, 0);
        drain();

        set_config(16'd2048, 16'd1000, 16'd0, 16'd1);
        add_sample(0, 4095, 1);
        add_sample(2048, 1, 0);
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            case ($urandom_range(0, 4))
                0: dz = 16'd0;
                1: dz = 16'd2048;
                2: dz = 16'($urandom_range(1900, 2100));
                3: dz = 16'($urandom_range(0, 4095));
                default: dz = 16'($urandom_range(0, 2048));
            endcase
            case ($urandom_range(0, 5))
                0: sens = 16'd0;
                1: sens = 16'd1;
                2: sens = 16'd1000;
                3: sens = 16'hFFFF;
                default: sens = 16'($urandom_range(0, 65535));
            endcase
            if (ph == 0) sens = 16'hFFFF;
            if (ph == 1) dz = 16'd0;
            set_config(dz, sens, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
            for (int n = 0; n < 200; n++) begin
                // flip occasionally so glitches and full runs both occur
                if ($urandom_range(0, 99) < 25) btn = !btn;
                add_sample(pick_raw(), pick_raw(), int'(btn));
            end
            drain();
        end

        repeat (60) @(posedge i_clk);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
